/* hdl/wwt_pkg.sv */
// Package for the write watchpoint table: field widths, request, status
// and page event codes shared by the channel interfaces and the unit.
// No dependencies.
`default_nettype none

package wwt_pkg;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 17;
  localparam int TIX_W  = 6;
  localparam int SLOT_W = 3;
  localparam int PSL_W  = 5;
  localparam int REF_W  = 4;

  typedef logic [1:0]        func_t;
  typedef logic [2:0]        status_t;
  typedef logic [1:0]        page_event_t;
  typedef logic [PSL_W-1:0]  psl_t;
  typedef logic [REF_W-1:0]  refcnt_t;

  localparam func_t FUNC_SET = 2'd0;
  localparam func_t FUNC_DEL = 2'd1;
  localparam func_t FUNC_ACC = 2'd2;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_INVALID = 3'd1;
  localparam status_t ST_BUSY    = 3'd2;
  localparam status_t ST_NOSPACE = 3'd3;
  localparam status_t ST_FAULT   = 3'd4;

  localparam page_event_t EV_NONE = 2'd0;
  localparam page_event_t EV_NEW  = 2'd1;
  localparam page_event_t EV_REL  = 2'd2;

  localparam psl_t PSL_MIN   = 5'd4;
  localparam psl_t PSL_MAX   = 5'd16;
  localparam psl_t PSL_RESET = 5'd12;

endpackage

`default_nettype wire

/* hdl/wwt_if.sv */
// Valid/ready channel interfaces for requests and results of the
// write watchpoint table. Depends on wwt_pkg.
`default_nettype none

interface wwt_in_if
  import wwt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  func_t               func;
  logic [ADDR_W-1:0]   addr;
  logic [LEN_W-1:0]    len;
  logic [TIX_W-1:0]    trap_index;

  modport source (output valid, func, addr, len, trap_index, input ready);
  modport sink   (input valid, func, addr, len, trap_index, output ready);
endinterface

interface wwt_out_if
  import wwt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [SLOT_W-1:0]   slot;
  logic                hit;
  page_event_t         page_event;

  modport source (output valid, status, slot, hit, page_event, input ready);
  modport sink   (input valid, status, slot, hit, page_event, output ready);
endinterface

`default_nettype wire

/* hdl/write_watchpoint_table_unit.sv */
// Write watchpoint table: watched address ranges plus protected pages with
// reference counts, searched by one shared compare unit under a sequencer.
// Depends on wwt_pkg and wwt_if.
//
//  channel   dir  signals                               transfer when
//  in_ch     in   func, addr, len, trap_index           valid && ready
//  out_ch    out  status, slot, hit, page_event         valid && ready
//  cfg       in   cfg_we, cfg_wdata (page_size_log2)    cfg_we high
//
// Set and access requests pass S_CHECK, S_SCAN, S_RESOLVE and S_EMIT: one
// compare unit walks the watch and page tables one entry per cycle through
// registered table reads. Delete passes S_DEL; a rejected request neither.
// in_ch.ready is high only in the idle state; a result waits in
// the output register and stalls only the next result, not the next request.
// Synchronous reset clears all watches, page counts and sets page size 4 KiB.
`default_nettype none

module write_watchpoint_table_unit
  import wwt_pkg::*;
#(
  parameter int NUM_WATCHES = 8,
  parameter int ADDR_WIDTH  = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  wwt_in_if.sink               in_ch,
  wwt_out_if.source            out_ch,
  input  wire logic            cfg_we,
  input  wire logic [PSL_W-1:0] cfg_wdata
);

  localparam int SAW = (ADDR_WIDTH < ADDR_W) ? ADDR_WIDTH : ADDR_W;
  localparam int IW  = (NUM_WATCHES > 1) ? $clog2(NUM_WATCHES) : 1;
  localparam int CW  = (SAW > LEN_W) ? SAW : LEN_W;
  localparam logic [IW-1:0]    LAST_IDX = IW'(NUM_WATCHES - 1);
  localparam logic [TIX_W:0]   NUM_IDX  = (TIX_W + 1)'(NUM_WATCHES);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_RESOLVE, S_DEL, S_EMIT
  } state_t;

  state_t              state_r;
  psl_t                psl_r;
  func_t               func_r;
  logic [SAW-1:0]      addr_r;
  logic [LEN_W-1:0]    len_r;
  logic [TIX_W-1:0]    tix_r;
  logic [SAW-1:0]      base_r;

  logic [NUM_WATCHES-1:0] active_r;
  refcnt_t             ref_r [NUM_WATCHES];

  // table storage
  logic [SAW-1:0]      wstart_mem [NUM_WATCHES];
  logic [LEN_W-1:0]    wlen_mem   [NUM_WATCHES];
  logic [IW-1:0]       wpslot_mem [NUM_WATCHES];
  logic [SAW-1:0]      pbase_mem  [NUM_WATCHES];
  logic [SAW-1:0]      wstart_q;
  logic [LEN_W-1:0]    wlen_q;
  logic [IW-1:0]       wpslot_q;
  logic [SAW-1:0]      pbase_q;

  // scan sequencer
  logic                issue_r;
  logic [IW-1:0]       sc_r;
  logic                ev_v_r;
  logic [IW-1:0]       ev_idx_r;
  logic                ov_f_r, wfree_f_r, hit_f_r, pg_f_r, pfree_f_r;
  logic [IW-1:0]       wfree_idx_r, hit_idx_r, pg_idx_r, pfree_idx_r;

  // pending result
  status_t             res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                res_hit_r;
  page_event_t         res_event_r;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_hit_r;
  page_event_t         out_event_r;

  psl_t                psl_sat;
  logic [LEN_W-1:0]    page_bytes;
  logic [SAW-1:0]      base_c;
  logic                set_bad;
  logic                del_ok;
  logic [IW-1:0]       rd_idx;

  logic [SAW:0]        diff;
  logic [SAW-1:0]      ndiff;
  logic                ge;
  logic                in_w, in_new;
  logic                e_ov, e_hit, e_wfree, e_pmatch, e_pfree;

  logic                set_commit;
  logic [IW-1:0]       p_sel;
  logic                del_last;

  always_comb begin
    if (psl_r < PSL_MIN) begin
      psl_sat = PSL_MIN;
    end else if (psl_r > PSL_MAX) begin
      psl_sat = PSL_MAX;
    end else begin
      psl_sat = psl_r;
    end
    page_bytes = LEN_W'(1) << psl_sat;
    base_c     = addr_r & ({SAW{1'b1}} << psl_sat);
    set_bad    = (base_c == '0) || (len_r == '0) || (len_r > page_bytes);
    del_ok     = ({1'b0, tix_r} < NUM_IDX) && active_r[tix_r[IW-1:0]];
    rd_idx     = (state_r == S_SCAN) ? sc_r : tix_r[IW-1:0];
  end

  // shared compare unit, one table entry per cycle
  always_comb begin
    diff     = {1'b0, addr_r} - {1'b0, wstart_q};
    ndiff    = wstart_q - addr_r;
    ge       = !diff[SAW];
    in_w     = CW'(diff[SAW-1:0]) < CW'(wlen_q);
    in_new   = CW'(ndiff) < CW'(len_r);
    e_hit    = active_r[ev_idx_r] && ge && in_w;
    e_ov     = active_r[ev_idx_r] && (ge ? in_w : in_new);
    e_wfree  = !active_r[ev_idx_r];
    e_pmatch = (ref_r[ev_idx_r] != '0) && (pbase_q == base_r);
    e_pfree  = (ref_r[ev_idx_r] == '0) && (ev_idx_r != '0);
  end

  always_comb begin
    set_commit = (state_r == S_RESOLVE) && (func_r == FUNC_SET) && !ov_f_r && wfree_f_r;
    if (pg_f_r) begin
      p_sel = pg_idx_r;
    end else if (pfree_f_r) begin
      p_sel = pfree_idx_r;
    end else begin
      p_sel = '0;
    end
    del_last = (ref_r[wpslot_q] == REF_W'(1));
  end

  always_ff @(posedge clk) begin
    if (set_commit) begin
      wstart_mem[wfree_idx_r] <= addr_r;
      wlen_mem[wfree_idx_r]   <= len_r;
      wpslot_mem[wfree_idx_r] <= p_sel;
      if (!pg_f_r) begin
        pbase_mem[p_sel] <= base_r;
      end
    end
    wstart_q <= wstart_mem[rd_idx];
    wlen_q   <= wlen_mem[rd_idx];
    wpslot_q <= wpslot_mem[rd_idx];
    pbase_q  <= pbase_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      psl_r       <= PSL_RESET;
      active_r    <= '0;
      for (int i = 0; i < NUM_WATCHES; i++) begin
        ref_r[i] <= '0;
      end
      issue_r     <= 1'b0;
      ev_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        psl_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            addr_r  <= in_ch.addr[SAW-1:0];
            len_r   <= in_ch.len;
            tix_r   <= in_ch.trap_index;
            state_r <= S_CHECK;
          end
        end

        S_CHECK: begin
          base_r       <= base_c;
          res_status_r <= ST_INVALID;
          res_slot_r   <= '0;
          res_hit_r    <= 1'b0;
          res_event_r  <= EV_NONE;
          ov_f_r       <= 1'b0;
          wfree_f_r    <= 1'b0;
          hit_f_r      <= 1'b0;
          pg_f_r       <= 1'b0;
          pfree_f_r    <= 1'b0;
          sc_r         <= LAST_IDX;
          priority if (func_r == FUNC_SET && !set_bad) begin
            issue_r <= 1'b1;
            state_r <= S_SCAN;
          end else if (func_r == FUNC_ACC) begin
            issue_r <= 1'b1;
            state_r <= S_SCAN;
          end else if (func_r == FUNC_DEL && del_ok) begin
            state_r <= S_DEL;
          end else begin
            state_r <= S_EMIT;
          end
        end

        S_SCAN: begin
          if (ev_v_r) begin
            if (e_ov && !ov_f_r) begin
              ov_f_r <= 1'b1;
            end
            if (e_wfree && !wfree_f_r) begin
              wfree_f_r   <= 1'b1;
              wfree_idx_r <= ev_idx_r;
            end
            if (e_hit && !hit_f_r) begin
              hit_f_r   <= 1'b1;
              hit_idx_r <= ev_idx_r;
            end
            if (e_pmatch && !pg_f_r) begin
              pg_f_r   <= 1'b1;
              pg_idx_r <= ev_idx_r;
            end
            if (e_pfree && !pfree_f_r) begin
              pfree_f_r   <= 1'b1;
              pfree_idx_r <= ev_idx_r;
            end
          end
          if (issue_r) begin
            ev_v_r   <= 1'b1;
            ev_idx_r <= sc_r;
            if (sc_r == '0) begin
              issue_r <= 1'b0;
            end else begin
              sc_r <= sc_r - IW'(1);
            end
          end else begin
            ev_v_r <= 1'b0;
            if (ev_v_r) begin
              state_r <= S_RESOLVE;
            end
          end
        end

        S_RESOLVE: begin
          state_r <= S_EMIT;
          if (func_r == FUNC_SET) begin
            priority if (ov_f_r) begin
              res_status_r <= ST_BUSY;
            end else if (!wfree_f_r) begin
              res_status_r <= ST_NOSPACE;
            end else begin
              res_status_r          <= ST_OK;
              res_slot_r            <= SLOT_W'(wfree_idx_r);
              active_r[wfree_idx_r] <= 1'b1;
              if (pg_f_r) begin
                ref_r[p_sel] <= ref_r[p_sel] + REF_W'(1);
                res_event_r  <= EV_NONE;
              end else begin
                ref_r[p_sel] <= REF_W'(1);
                res_event_r  <= EV_NEW;
              end
            end
          end else begin
            priority if (!pg_f_r) begin
              res_status_r <= ST_FAULT;
            end else if (hit_f_r) begin
              res_status_r <= ST_OK;
              res_slot_r   <= SLOT_W'(hit_idx_r);
              res_hit_r    <= 1'b1;
            end else begin
              res_status_r <= ST_OK;
            end
          end
        end

        S_DEL: begin
          active_r[tix_r[IW-1:0]] <= 1'b0;
          res_status_r <= ST_OK;
          if (ref_r[wpslot_q] != '0) begin
            ref_r[wpslot_q] <= ref_r[wpslot_q] - REF_W'(1);
            res_event_r     <= del_last ? EV_REL : EV_NONE;
          end
          state_r <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_hit_r    <= res_hit_r;
            out_event_r  <= res_event_r;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.page_event = out_event_r;

endmodule

`default_nettype wire

/* bench/wwt_watch_checker.sv */
`timescale 1ns / 100ps
// Checker for the write watchpoint table: watches request, result and page-size
// ports, predicts each result from its own copy of the tables, compares fields.
// Depends on wwt_pkg and the channel interfaces of wwt_if.
module wwt_watch_checker
  import wwt_pkg::*;
#(
  parameter int NUM_WATCHES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  wwt_in_if                in_mon,
  wwt_out_if               out_mon,
  input  logic             cfg_we,
  input  logic [PSL_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending_results,
  output int               results_checked,
  output int               hits_seen,
  output int               faults_seen
);

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    page_event_t       page_event;
  } watch_result_t;

  logic [ADDR_W-1:0] watch_start [NUM_WATCHES];
  logic [LEN_W-1:0]  watch_len   [NUM_WATCHES];
  logic [SLOT_W-1:0] watch_page  [NUM_WATCHES];
  logic [ADDR_W-1:0] page_base   [NUM_WATCHES];
  refcnt_t           page_refs   [NUM_WATCHES];
  psl_t              page_size_log2;
  watch_result_t     expected_results [$];

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] transfer mismatch: %s", $time, what);
  endtask

  // no wrap: compared in 64 bits
  function automatic bit spans_meet(bit [63:0] a, bit [63:0] la, bit [63:0] b,
                                    bit [63:0] lb);
    if (a >= b) return (a - b) < lb;
    return (b - a) < la;
  endfunction

  function automatic int find_page(logic [ADDR_W-1:0] base);
    for (int p = NUM_WATCHES - 1; p >= 0; p--) begin
      if (page_refs[p] != 0 && page_base[p] == base) return p;
    end
    return -1;
  endfunction

  task automatic predict_watch_result(input func_t func, input logic [ADDR_W-1:0] addr,
                                      input logic [LEN_W-1:0] len,
                                      input logic [TIX_W-1:0] tix,
                                      output watch_result_t r);
    psl_t              eff;
    bit [63:0]         ps;
    logic [ADDR_W-1:0] base;
    int                t;
    int                p;
    r = '0;
    eff = (page_size_log2 < PSL_MIN) ? PSL_MIN :
          (page_size_log2 > PSL_MAX) ? PSL_MAX : page_size_log2;
    ps = 64'd1 << eff;
    base = addr & ~(ps[ADDR_W-1:0] - 1'b1);
    case (func)
      FUNC_SET: begin
        t = -1;
        if (base == '0 || len == '0 || len > ps) begin
          r.status = ST_INVALID;
        end else begin
          for (int i = 0; i < NUM_WATCHES; i++) begin
            if (watch_len[i] != 0 && spans_meet(addr, len, watch_start[i], watch_len[i]))
              r.status = ST_BUSY;
          end
          if (r.status == ST_OK) begin
            for (int i = 0; i < NUM_WATCHES; i++) begin
              if (watch_len[i] == 0) t = i;
            end
            if (t < 0) begin
              r.status = ST_NOSPACE;
            end else begin
              p = find_page(base);
              if (p < 0) begin
                p = NUM_WATCHES - 1;
                while (p > 0 && page_refs[p] != 0) p--;
                page_base[p] = base;
                page_refs[p] = '0;
                r.page_event = EV_NEW;
              end
              page_refs[p] = page_refs[p] + 1'b1;
              watch_start[t] = addr;
              watch_len[t] = len;
              watch_page[t] = p[SLOT_W-1:0];
              r.slot = t[SLOT_W-1:0];
            end
          end
        end
      end
      FUNC_DEL: begin
        if (tix >= NUM_WATCHES || watch_len[tix] == 0) begin
          r.status = ST_INVALID;
        end else begin
          p = watch_page[tix];
          if (page_refs[p] != 0) begin
            page_refs[p] = page_refs[p] - 1'b1;
            if (page_refs[p] == 0) r.page_event = EV_REL;
          end
          watch_len[tix] = '0;
        end
      end
      FUNC_ACC: begin
        if (find_page(base) < 0) begin
          r.status = ST_FAULT;
        end else begin
          for (int i = 0; i < NUM_WATCHES; i++) begin
            if (watch_len[i] != 0 && addr >= watch_start[i] &&
                (addr - watch_start[i]) < watch_len[i]) begin
              r.hit = 1'b1;
              r.slot = i[SLOT_W-1:0];
            end
          end
        end
      end
      default: r.status = ST_INVALID;
    endcase
  endtask

  always @(posedge clk) begin
    watch_result_t exp_r;
    watch_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_WATCHES; i++) begin
        watch_start[i] = '0;
        watch_len[i] = '0;
        watch_page[i] = '0;
        page_base[i] = '0;
        page_refs[i] = '0;
      end
      page_size_log2 = PSL_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) page_size_log2 = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got.status = out_mon.status;
        got.slot = out_mon.slot;
        got.hit = out_mon.hit;
        got.page_event = out_mon.page_event;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with no request outstanding");
        end else begin
          exp_r = expected_results.pop_front();
          results_checked++;
          if (exp_r.hit) hits_seen++;
          if (exp_r.status == ST_FAULT) faults_seen++;
          if (got !== exp_r)
            report_mismatch($sformatf(
              "got/exp status %0d/%0d slot %0d/%0d hit %0d/%0d page_event %0d/%0d",
              got.status, exp_r.status, got.slot, exp_r.slot, got.hit, exp_r.hit,
              got.page_event, exp_r.page_event));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_watch_result(in_mon.func, in_mon.addr, in_mon.len, in_mon.trap_index, exp_r);
        expected_results.push_back(exp_r);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

/* bench/write_watchpoint_table_unit_tb.sv */
`timescale 1ns / 100ps
// Testbench top for write_watchpoint_table_unit: drives requests and page-size
// writes, stalls both channels and gives the verdict from wwt_watch_checker.
// Depends on wwt_pkg, wwt_if, wwt_watch_checker and the unit.
module write_watchpoint_table_unit_tb;
  import wwt_pkg::*;

  localparam int    NUM_WATCHES       = 8;
  localparam int    ITEMS_PER_SETTING = 150;
  localparam int    NUM_SETTINGS      = 9;
  localparam int    DRAIN_CYCLES      = NUM_WATCHES + 12;
  localparam func_t FUNC_UNUSED       = 2'd3;
  localparam logic [PSL_W-1:0] PAGE_SETTINGS [NUM_SETTINGS] =
    '{5'd4, 5'd16, 5'd0, 5'd31, 5'd12, 5'd5, 5'd8, 5'd17, 5'd3};

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [PSL_W-1:0] cfg_wdata;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               requests_sent;
  int               fail_count;
  int               pending_results;
  int               results_checked;
  int               hits_seen;
  int               faults_seen;

  wwt_in_if  in_ch();
  wwt_out_if out_ch();

  write_watchpoint_table_unit #(
    .NUM_WATCHES(NUM_WATCHES),
    .ADDR_WIDTH (ADDR_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  wwt_watch_checker #(
    .NUM_WATCHES(NUM_WATCHES)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .results_checked(results_checked),
    .hits_seen      (hits_seen),
    .faults_seen    (faults_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_request(input func_t func, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len, input logic [TIX_W-1:0] tix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = func;
    in_ch.addr = addr;
    in_ch.len = len;
    in_ch.trap_index = tix;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    requests_sent++;
  endtask

  task automatic wait_results_drained();
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_page_size(input logic [PSL_W-1:0] value);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] hot_base;
    logic [ADDR_W-1:0] a;
    logic [LEN_W-1:0]  l;
    logic [TIX_W-1:0]  tix;
    func_t             f;
    int                eff_log2;
    int                ps;
    int                roll;
    int                pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_SET;
    in_ch.addr = '0;
    in_ch.len = '0;
    in_ch.trap_index = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 45;
    requests_sent = 0;
    hot_base = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed, 4 KiB pages after reset
    send_request(FUNC_SET, 32'h0000_0010, 17'd16, '0);
    send_request(FUNC_SET, 32'h0000_1000, 17'd0, '0);
    send_request(FUNC_SET, 32'h0000_1000, 17'd4097, '0);
    send_request(FUNC_SET, 32'h0000_1000, 17'd4096, '0);
    send_request(FUNC_SET, 32'h0000_1800, 17'd16, '0);
    send_request(FUNC_SET, 32'h0000_2000, 17'd16, '0);
    send_request(FUNC_SET, 32'hFFFF_FFF0, 17'd4096, '0);
    send_request(FUNC_ACC, 32'h0000_0005, '0, '0);
    send_request(FUNC_ACC, 32'hFFFF_FFFF, 17'h1FFFF, 6'd63);
    send_request(FUNC_ACC, 32'h0000_1FFF, '0, '0);
    send_request(FUNC_ACC, 32'h0000_2010, '0, '0);
    send_request(FUNC_SET, 32'h0000_2FF0, 17'd32, '0);
    send_request(FUNC_ACC, 32'h0000_3008, '0, '0);
    send_request(FUNC_DEL, '0, '0, 6'd63);
    send_request(FUNC_DEL, '0, '0, 6'd0);
    send_request(FUNC_DEL, '0, '0, 6'd6);
    send_request(FUNC_DEL, '0, '0, 6'd4);
    send_request(FUNC_UNUSED, 32'h0000_1000, 17'd16, '0);
    // fill the table, last one finds no slot
    for (int k = 1; k <= 7; k++) begin
      send_request(FUNC_SET, ADDR_W'(k * 32'h0001_0000), 17'd1, '0);
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s == 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 22;
      end
      if (s == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_page_size(PAGE_SETTINGS[s]);
      eff_log2 = (PAGE_SETTINGS[s] < PSL_MIN) ? PSL_MIN :
                 (PAGE_SETTINGS[s] > PSL_MAX) ? PSL_MAX : PAGE_SETTINGS[s];
      ps = 1 << eff_log2;
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        // move the working window now and then: low page, top of space, anywhere
        if (i % 40 == 0) begin
          pick = $urandom_range(3);
          if (pick == 0) hot_base = '0;
          else if (pick == 1) hot_base = ADDR_W'(-3 * ps);
          else hot_base = $urandom & ~ADDR_W'(ps - 1);
        end
        if (s == 4 && i == ITEMS_PER_SETTING / 2) wait_results_drained();
        roll = $urandom_range(99);
        f = func_t'($urandom_range(3));
        a = $urandom;
        l = LEN_W'($urandom);
        tix = TIX_W'($urandom);
        if (roll < 45) begin
          f = FUNC_SET;
          a = hot_base + ADDR_W'($urandom_range(3 * ps - 1));
          pick = $urandom_range(19);
          if (pick == 0) l = '0;
          else if (pick == 1) l = LEN_W'($urandom_range(ps + 1, 17'h1FFFF));
          else if (pick == 2) l = LEN_W'(ps);
          else l = LEN_W'($urandom_range(1, ps / 2));
        end else if (roll < 65) begin
          f = FUNC_DEL;
          if ($urandom_range(9) == 0) tix = TIX_W'($urandom_range(63, NUM_WATCHES));
          else tix = TIX_W'($urandom_range(NUM_WATCHES - 1));
        end else if (roll < 95) begin
          f = FUNC_ACC;
          if ($urandom_range(9) != 0) a = hot_base + ADDR_W'($urandom_range(3 * ps - 1));
        end
        send_request(f, a, l, tix);
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d requests under %0d page sizes, saturated ones included;",
             requests_sent, NUM_SETTINGS + 1);
    $display("%0d results compared, %0d watch hits, %0d unprotected-page faults.",
             results_checked, hits_seen, faults_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
